/* design/msd_pkg.sv */
// Shared types, constants and the character decode table for the seven-segment driver.
package msd_pkg;

   localparam int DIGIT_COUNT = 8;
   localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int DIGIT_W     = 4;
   localparam int SEG_W       = 8;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_CHAR    = 2'd1,
      MODE_POINT   = 2'd2,
      MODE_SEGMENT = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [DIGIT_W-1:0]   digit;
      logic [7:0]           char_code;
      logic [3:0]           segment_number;
      logic                 turn_on;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]   active_digit;
      logic [SEG_W-1:0]     segment_pattern;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tick_pending;
      logic out_free;
   } dp_status_type;

   function automatic logic [SEG_W-1:0] decode_char(input logic [7:0] code);
      logic [SEG_W-1:0] pat;
      case (code)
         8'd45:   pat = 8'h02;
         8'd48:   pat = 8'hfc;
         8'd49:   pat = 8'h60;
         8'd50:   pat = 8'hda;
         8'd51:   pat = 8'hf2;
         8'd52:   pat = 8'h66;
         8'd53:   pat = 8'hb6;
         8'd54:   pat = 8'hbe;
         8'd55:   pat = 8'he0;
         8'd56:   pat = 8'hfe;
         8'd57:   pat = 8'hf6;
         8'd65:   pat = 8'hee;
         8'd66:   pat = 8'h3e;
         8'd67:   pat = 8'h9c;
         8'd68:   pat = 8'h7a;
         8'd69:   pat = 8'h9e;
         8'd70:   pat = 8'h8e;
         8'd71:   pat = 8'hbe;
         8'd72:   pat = 8'h6e;
         8'd73:   pat = 8'h60;
         8'd74:   pat = 8'h78;
         8'd76:   pat = 8'h1c;
         8'd78:   pat = 8'h2a;
         8'd79:   pat = 8'h3a;
         8'd80:   pat = 8'hce;
         8'd82:   pat = 8'h0a;
         8'd83:   pat = 8'hb6;
         8'd84:   pat = 8'h1e;
         8'd85:   pat = 8'h7c;
         8'd89:   pat = 8'h76;
         8'd95:   pat = 8'h10;
         8'd175:  pat = 8'h80;
         8'd176:  pat = 8'hc6;
         8'd186:  pat = 8'hd6;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* design/msd_ctrl.sv */
// Controller state machine that sequences capture and execution of each request beat.
module msd_ctrl
   import msd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!status.tick_pending || status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/msd_dp.sv */
// Datapath holding the captured beat, the pattern store, the scan index and the output register.
module msd_dp
   import msd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   req_type          item_ff;
   logic [SEG_W-1:0] store_ff [DIGIT_COUNT];
   logic [IDX_W-1:0] scan_ff;
   logic [IDX_W-1:0] scan_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             is_tick;
   logic             digit_ok;
   logic             seg_ok;
   logic [IDX_W-1:0] rd_idx;
   logic [SEG_W-1:0] entry;
   logic [SEG_W-1:0] entry_in;
   logic [SEG_W-1:0] seg_mask;
   logic [SEG_W-1:0] glyph;
   logic             write_en;
   logic             load_rsp;

   assign is_tick  = (item_ff.mode == MODE_TICK);
   assign digit_ok = ({1'b0, item_ff.digit} < (DIGIT_W + 1)'(DIGIT_COUNT));
   assign seg_ok   = item_ff.segment_number inside {[4'd1:4'd8]};
   assign rd_idx   = is_tick ? scan_ff : item_ff.digit[IDX_W-1:0];
   assign entry    = store_ff[rd_idx];
   assign seg_mask = 8'h80 >> (item_ff.segment_number - 4'd1);
   assign glyph    = decode_char(item_ff.char_code);
   assign scan_in  = (scan_ff == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + 1'b1;

   always_comb begin
      entry_in = entry;
      write_en = 1'b0;
      case (item_ff.mode)
         MODE_CHAR: begin
            entry_in = {glyph[SEG_W-1:1], entry[0]};
            write_en = digit_ok;
         end
         MODE_POINT: begin
            entry_in = {entry[SEG_W-1:1], item_ff.turn_on};
            write_en = digit_ok;
         end
         MODE_SEGMENT: begin
            entry_in = item_ff.turn_on ? (entry | seg_mask) : (entry & ~seg_mask);
            write_en = digit_ok && seg_ok;
         end
         default: begin
            entry_in = entry;
            write_en = 1'b0;
         end
      endcase
   end

   assign load_rsp = cmd.execute && is_tick;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_ff.active_digit    <= DIGIT_W'(scan_ff);
         rsp_ff.segment_pattern <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '{default: '0};
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute && write_en) begin
            store_ff[rd_idx] <= entry_in;
         end
         if (load_rsp) begin
            scan_ff      <= scan_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.tick_pending = is_tick;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_ff;

endmodule

/* design/multiplexed_seven_segment_driver.sv */
// Top level of the multiplexed seven-segment driver.
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    req_type: mode, digit, char, segment, turn_on
//  rsp_      out        rsp_valid/rsp_ready    rsp_type: active_digit, segment_pattern
// Each request beat is captured in the idle state and then, in the execute state, goes through the
// read-modify-write of the pattern store through its single read port.
// A tick waits in execution while the output register still holds an untaken beat.
// Reset is synchronous and clears the pattern store, the scan index and all control state.
module multiplexed_seven_segment_driver
   import msd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   msd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/msd_checker.sv */
// Port-level checker for the seven-segment driver and its bind to the top level.
module msd_checker
   import msd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_clears_rsp: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("Result beat valid straight after reset.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled result beat changed or vanished.");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.active_digit} < (DIGIT_W + 1)'(DIGIT_COUNT)))
      else $error("Active digit beyond the digit count.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Request beat accepted while the previous one is still executing.");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/multiplexed_seven_segment_driver_test.sv */
// Self-checking testbench for the multiplexed seven-segment driver.
module multiplexed_seven_segment_driver_test;
   import msd_pkg::*;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [SEG_W-1:0] digit_patterns [DIGIT_COUNT];
   int               scan_pos;
   rsp_type          expected_frames [$];
   script_row_type   script [25];
   int               failures = 0;
   int               frames_seen = 0;
   int               burst_left = 0;
   int               written_items = 0;
   bit               held_off = 1'b0;

   multiplexed_seven_segment_driver dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      failures++;
   endtask

   function automatic logic [SEG_W-1:0] glyph_of(input logic [7:0] code);
      case (code)
         "-":     return 8'h02;
         "0":     return 8'hfc;
         "1":     return 8'h60;
         "2":     return 8'hda;
         "3":     return 8'hf2;
         "4":     return 8'h66;
         "5":     return 8'hb6;
         "6":     return 8'hbe;
         "7":     return 8'he0;
         "8":     return 8'hfe;
         "9":     return 8'hf6;
         "A":     return 8'hee;
         "B":     return 8'h3e;
         "C":     return 8'h9c;
         "D":     return 8'h7a;
         "E":     return 8'h9e;
         "F":     return 8'h8e;
         "G":     return 8'hbe;
         "H":     return 8'h6e;
         "I":     return 8'h60;
         "J":     return 8'h78;
         "L":     return 8'h1c;
         "N":     return 8'h2a;
         "O":     return 8'h3a;
         "P":     return 8'hce;
         "R":     return 8'h0a;
         "S":     return 8'hb6;
         "T":     return 8'h1e;
         "U":     return 8'h7c;
         "Y":     return 8'h76;
         "_":     return 8'h10;
         8'd175:  return 8'h80;
         8'd176:  return 8'hc6;
         8'd186:  return 8'hd6;
         default: return 8'h00;
      endcase
   endfunction

   // Updates the display image for one beat and returns whether it yields a frame.
   function automatic bit apply_request(input req_type item, output rsp_type frame);
      int d;
      int s;
      frame = '0;
      d = item.digit;
      s = item.segment_number;
      if (item.mode == MODE_TICK) begin
         frame.active_digit    = DIGIT_W'(scan_pos);
         frame.segment_pattern = digit_patterns[scan_pos];
         scan_pos = (scan_pos == DIGIT_COUNT - 1) ? 0 : scan_pos + 1;
         return 1'b1;
      end
      if (d >= DIGIT_COUNT) return 1'b0;
      case (item.mode)
         MODE_CHAR: begin
            digit_patterns[d] = (digit_patterns[d] & 8'h01) | glyph_of(item.char_code);
         end
         MODE_POINT: begin
            digit_patterns[d][0] = item.turn_on;
         end
         default: begin
            if (s >= 1 && s <= 8) digit_patterns[d][8 - s] = item.turn_on;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic script_row_type row(input mode_type m, input int d, input int c,
                                          input int s, input bit on, input bit typed,
                                          input int ad, input int pat);
      script_row_type r;
      r.item.mode           = m;
      r.item.digit          = DIGIT_W'(d);
      r.item.char_code      = 8'(c);
      r.item.segment_number = 4'(s);
      r.item.turn_on        = on;
      r.typed               = typed;
      r.want.active_digit   = DIGIT_W'(ad);
      r.want.segment_pattern = SEG_W'(pat);
      return r;
   endfunction

   // Returns a random beat and whether it changes the display or yields a frame.
   function automatic bit random_request(output req_type item);
      int pick;
      int s;
      pick = $urandom_range(0, 99);
      item.digit          = ($urandom_range(0, 9) == 0) ? DIGIT_W'($urandom_range(DIGIT_COUNT, 15))
                                                        : DIGIT_W'($urandom_range(0, DIGIT_COUNT - 1));
      item.char_code      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(45, 95));
      if ($urandom_range(0, 19) == 0) item.char_code = 8'($urandom_range(175, 186));
      item.segment_number = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 8));
      item.turn_on        = 1'($urandom_range(0, 1));
      if (pick < 30) item.mode = MODE_TICK;
      else if (pick < 55) item.mode = MODE_CHAR;
      else if (pick < 70) item.mode = MODE_POINT;
      else item.mode = MODE_SEGMENT;
      s = item.segment_number;
      if (item.mode == MODE_TICK) return 1'b1;
      if (item.digit >= DIGIT_COUNT) return 1'b0;
      if (item.mode == MODE_SEGMENT && (s < 1 || s > 8)) return 1'b0;
      return 1'b1;
   endfunction

   task automatic offer(input req_type item, input bit typed, input rsp_type typed_frame);
      rsp_type frame;
      bit      has_frame;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      has_frame = apply_request(item, frame);
      if (has_frame) expected_frames.push_back(typed ? typed_frame : frame);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(0, 24);
      end else begin
         burst_left--;
      end
   endtask

   always @(posedge clock) begin : frame_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         frames_seen++;
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected beat digit %0d pattern %02h",
                                      rsp_data.active_digit, rsp_data.segment_pattern));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_data.active_digit !== want.active_digit)
               report_mismatch($sformatf("active_digit %0d, expected %0d",
                                         rsp_data.active_digit, want.active_digit));
            if (rsp_data.segment_pattern !== want.segment_pattern)
               report_mismatch($sformatf("segment_pattern %02h, expected %02h",
                                         rsp_data.segment_pattern, want.segment_pattern));
         end
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int style;
         int span;
         if (!held_off && frames_seen >= 40) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (150) @(negedge clock);
         end
         style = $urandom_range(0, 2);
         span  = $urandom_range(8, 40);
         repeat (span) begin
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      #(12 * 400000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_type item;
      for (int i = 0; i < DIGIT_COUNT; i++) digit_patterns[i] = '0;
      scan_pos = 0;

      script[0]  = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b1, 0, 8'h00);
      script[1]  = row(MODE_CHAR,     1,  56,  0, 1'b0, 1'b0, 0, 0);
      script[2]  = row(MODE_POINT,    1,   0,  0, 1'b1, 1'b0, 0, 0);
      script[3]  = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b1, 1, 8'hff);
      script[4]  = row(MODE_POINT,    2,   0,  0, 1'b1, 1'b0, 0, 0);
      script[5]  = row(MODE_CHAR,     2, 255,  0, 1'b0, 1'b0, 0, 0);
      script[6]  = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b1, 2, 8'h01);
      script[7]  = row(MODE_CHAR,    15,  48,  0, 1'b0, 1'b0, 0, 0);
      script[8]  = row(MODE_SEGMENT,  3,   0,  0, 1'b1, 1'b0, 0, 0);
      script[9]  = row(MODE_SEGMENT,  3,   0,  9, 1'b1, 1'b0, 0, 0);
      script[10] = row(MODE_SEGMENT,  3,   0, 15, 1'b1, 1'b0, 0, 0);
      script[11] = row(MODE_SEGMENT,  3,   0,  1, 1'b1, 1'b0, 0, 0);
      script[12] = row(MODE_SEGMENT,  3,   0,  8, 1'b1, 1'b0, 0, 0);
      script[13] = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b1, 3, 8'h81);
      script[14] = row(MODE_SEGMENT,  4,   0,  4, 1'b1, 1'b0, 0, 0);
      script[15] = row(MODE_POINT,    8,   0,  0, 1'b1, 1'b0, 0, 0);
      script[16] = row(MODE_SEGMENT,  4,   0,  7, 1'b1, 1'b0, 0, 0);
      script[17] = row(MODE_SEGMENT,  4,   0,  4, 1'b0, 1'b0, 0, 0);
      script[18] = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b0, 0, 0);
      script[19] = row(MODE_CHAR,     7, 186,  0, 1'b0, 1'b0, 0, 0);
      script[20] = row(MODE_POINT,    7,   0,  0, 1'b0, 1'b0, 0, 0);
      script[21] = row(MODE_TICK,    15, 255, 15, 1'b1, 1'b0, 0, 0);
      script[22] = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b0, 0, 0);
      script[23] = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b0, 0, 0);
      script[24] = row(MODE_TICK,     0,   0,  0, 1'b0, 1'b1, 0, 8'h00);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) offer(script[i].item, script[i].typed, script[i].want);

      while (written_items < 625) begin
         void'(random_request(item));
         offer(item, 1'b0, '0);
         written_items++;
      end
      req_valid <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_frames.size() != 0) report_mismatch("beats still outstanding at the end");

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
design/msd_pkg.sv
design/msd_ctrl.sv
design/msd_dp.sv
design/multiplexed_seven_segment_driver.sv
design/msd_checker.sv
tb/sv/multiplexed_seven_segment_driver_test.sv
